// ----- sv/dmm_pkg.sv -----
package dmm_pkg;

    localparam int IDX_W      = 6;
    localparam int MAX_N      = 1 << IDX_W;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 40;
    localparam int SIZE_W     = 7;
    localparam int OP_W       = 2;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_N);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic write_a;
        logic write_b;
        logic start;
        logic issue;
        logic load_out;
    } dmm_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic last_k;
        logic pipe_busy;
        logic out_free;
    } dmm_status_t;

endpackage

// ----- sv/dmm_ctrl.sv -----
module dmm_ctrl
    import dmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [OP_W-1:0] operation,
    input  dmm_status_t status,
    output dmm_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (operation)
                        OP_LOAD_A: cmd.write_a = 1'b1;
                        OP_LOAD_B: cmd.write_b = 1'b1;
                        OP_READ: begin
                            cmd.start  = 1'b1;
                            state_next = status.n_zero ? ST_DONE : ST_ISSUE;
                        end
                        default: ; // unused code: item dropped
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/dmm_datapath.sv -----
module dmm_datapath
    import dmm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [SIZE_W-1:0]        cfg_wr_data,
    input  dmm_cmd_t                 cmd,
    output dmm_status_t              status,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [ELEM_W-1:0] value,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [IDX_W-1:0]         result_row,
    output logic [IDX_W-1:0]         result_col,
    output logic signed [ACC_W-1:0]  product
);

    logic [SIZE_W-1:0]        size_reg;
    logic [SIZE_W-1:0]        n_eff;
    logic [IDX_W-1:0]         row_reg, col_reg, k_reg;
    logic signed [ELEM_W-1:0] a_mem [2**ADDR_W];
    logic signed [ELEM_W-1:0] b_mem [2**ADDR_W];
    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     rd_vld_reg, prod_vld_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0]  out_prod_reg;
    logic [ADDR_W-1:0]        w_addr, a_raddr, b_raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    assign n_eff   = (size_reg > SIZE_MAX) ? SIZE_MAX : size_reg;
    assign w_addr  = {row, col};
    assign a_raddr = {row_reg, k_reg};
    assign b_raddr = {k_reg, col_reg};

    // element stores: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.write_a) begin
            a_mem[w_addr] <= value;
        end
        a_rd_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_b) begin
            b_mem[w_addr] <= value;
        end
        b_rd_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            row_reg <= row;
            col_reg <= col;
            k_reg   <= '0;
        end else if (cmd.issue) begin
            k_reg <= k_reg + IDX_W'(1);
        end
        prod_reg <= a_rd_reg * b_rd_reg;
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // output register parts the result side from the work side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_prod_reg <= acc_reg;
        end
    end

    assign status.n_zero    = (n_eff == '0);
    assign status.last_k    = ({1'b0, k_reg} == (n_eff - SIZE_W'(1)));
    assign status.pipe_busy = rd_vld_reg | prod_vld_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign result_row = out_row_reg;
    assign result_col = out_col_reg;
    assign product    = out_prod_reg;

endmodule

// ----- sv/dense_matrix_multiply.sv -----
// Square matrix multiply C = A x B, n = matrix_size (saturated at 64). Load items write
// one Q8.8 element of A or B into its 64x64 store. A read item returns C[row][col] as
// an exact Q24.16 sum over n terms. It passes through an element walk over n terms, a
// drain of the read and multiply stages, and a load of the output register (when n is
// zero, only the load). The walk is set by the single multiply-accumulate that takes
// one element pair per cycle from the two store read ports. The load of the output
// register waits while an earlier result still waits there. No further item is taken
// until the sum is in the output register, but the next item is taken while the result
// waits there. Reading an element never loaded gives an undefined product. Write
// matrix_size only while idle.
module dense_matrix_multiply
    import dmm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [SIZE_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // operation[1:0], row[7:2], col[13:8], value[29:14]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // result_row[5:0], result_col[11:6], product[51:12]
);

    dmm_cmd_t                 cmd;
    dmm_status_t              status;
    logic [IDX_W-1:0]         result_row, result_col;
    logic signed [ACC_W-1:0]  product;

    dmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (s_tdata[1:0]),
        .status    (status),
        .cmd       (cmd)
    );

    dmm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .row         (s_tdata[7:2]),
        .col         (s_tdata[13:8]),
        .value       (s_tdata[29:14]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result_row  (result_row),
        .result_col  (result_col),
        .product     (product)
    );

    assign m_tdata = {4'b0, product, result_col, result_row};

`ifndef ASSERT_OFF
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.pipe_busy)
        else $error("item taken while accumulation still running");

    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result overwrote an item not yet taken");

    a_issue_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_tready)
        else $error("input ready during element walk");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("result not presented after load");
`endif

endmodule
